[rtl/alu128_pkg.sv]
// ----------------------------------------------------------------------------
// alu128_pkg
// Shared types and constants for the 128-bit integer ALU.
// ----------------------------------------------------------------------------
package alu128_pkg;

    // Default operand width.
    localparam int WORD_BITS_DEF = 128;

    // Operation codes.
    typedef enum logic [3:0] {
        KIND_ADD = 4'd0,
        KIND_SUB = 4'd1,
        KIND_MUL = 4'd2,
        KIND_DIV = 4'd3,
        KIND_AND = 4'd4,
        KIND_OR  = 4'd5,
        KIND_XOR = 4'd6,
        KIND_NOT = 4'd7,
        KIND_SHL = 4'd8,
        KIND_SHR = 4'd9,
        KIND_ROL = 4'd10,
        KIND_ROR = 4'd11,
        KIND_CMP = 4'd12
    } kind_t;

    // One input transfer.
    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] operand_a_high;
        logic [63:0] operand_a_low;
        logic [63:0] operand_b_high;
        logic [63:0] operand_b_low;
        logic [7:0]  shift_amount;
    } in_t;

    // One result transfer.
    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        less_than;
        logic        equal;
        logic        divide_by_zero;
    } out_t;

    // Control that travels with each item along the cell chain.
    typedef struct packed {
        logic       valid;
        logic [3:0] kind;
        logic       neg_q;
        logic       dz;
        logic       lt;
        logic       eq;
    } ctl_t;

endpackage

[rtl/alu128_pre.sv]
// ----------------------------------------------------------------------------
// alu128_pre
// Input stage: add, sub, logic, shifts, rotates, compare and setup of the
// multiply and divide chain, registered.
// ----------------------------------------------------------------------------
module alu128_pre
    import alu128_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  in_t                  op,
    output ctl_t                 ctl,
    output logic [WORD_BITS-1:0] acc,
    output logic [WORD_BITS-1:0] x,
    output logic [WORD_BITS-1:0] y,
    output logic [WORD_BITS:0]   rem
);

    localparam logic [8:0] W9 = 9'(WORD_BITS);

    logic [127:0]         a_full;
    logic [127:0]         b_full;
    logic [WORD_BITS-1:0] a_w;
    logic [WORD_BITS-1:0] b_w;
    logic [WORD_BITS-1:0] a_abs;
    logic [WORD_BITS-1:0] b_abs;
    logic [8:0]           rot_s;
    logic                 sa;
    logic                 sb;
    ctl_t                 ctl_reg, ctl_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;

    assign a_full = {op.operand_a_high, op.operand_a_low};
    assign b_full = {op.operand_b_high, op.operand_b_low};
    assign a_w    = a_full[WORD_BITS-1:0];
    assign b_w    = b_full[WORD_BITS-1:0];
    assign sa     = a_w[WORD_BITS-1];
    assign sb     = b_w[WORD_BITS-1];
    assign a_abs  = sa ? (~a_w + 1'b1) : a_w;
    assign b_abs  = sb ? (~b_w + 1'b1) : b_w;

    // Rotate amount reduced modulo the word width.
    always_comb
    begin
        rot_s = {1'b0, op.shift_amount};
        for (int i = 0; i < 4; i++)
        begin
            if (rot_s >= W9)
            begin
                rot_s = rot_s - W9;
            end
        end
    end

    // Operation select and chain setup.
    always_comb
    begin
        ctl_next       = '0;
        ctl_next.valid = take;
        ctl_next.kind  = op.kind;
        acc_next       = '0;
        x_next         = '0;
        y_next         = '0;
        unique case (op.kind)
            KIND_ADD: acc_next = a_w + b_w;
            KIND_SUB: acc_next = a_w - b_w;
            KIND_MUL:
            begin
                x_next = a_w;
                y_next = b_w;
            end
            KIND_DIV:
            begin
                x_next         = a_abs;
                y_next         = b_abs;
                ctl_next.neg_q = sa ^ sb;
                ctl_next.dz    = (b_w == '0);
            end
            KIND_AND: acc_next = a_w & b_w;
            KIND_OR:  acc_next = a_w | b_w;
            KIND_XOR: acc_next = a_w ^ b_w;
            KIND_NOT: acc_next = ~a_w;
            KIND_SHL: acc_next = a_w << op.shift_amount;
            KIND_SHR: acc_next = a_w >> op.shift_amount;
            KIND_ROL: acc_next = (a_w << rot_s) | (a_w >> (W9 - rot_s));
            KIND_ROR: acc_next = (a_w >> rot_s) | (a_w << (W9 - rot_s));
            KIND_CMP:
            begin
                ctl_next.eq = (a_w == b_w);
                ctl_next.lt = ($signed(a_w) < $signed(b_w));
            end
            default: ctl_next.kind = op.kind;
        endcase
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign ctl = ctl_reg;
    assign acc = acc_reg;
    assign x   = x_reg;
    assign y   = y_reg;
    assign rem = '0;

endmodule

[rtl/alu128_cell.sv]
// ----------------------------------------------------------------------------
// alu128_cell
// One cell of the chain: a shift-and-add multiply step or a restoring
// divide step, registered, passing everything else through.
// ----------------------------------------------------------------------------
module alu128_cell
    import alu128_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_t                 ctl_in,
    input  logic [WORD_BITS-1:0] acc_in,
    input  logic [WORD_BITS-1:0] x_in,
    input  logic [WORD_BITS-1:0] y_in,
    input  logic [WORD_BITS:0]   rem_in,
    output ctl_t                 ctl_out,
    output logic [WORD_BITS-1:0] acc_out,
    output logic [WORD_BITS-1:0] x_out,
    output logic [WORD_BITS-1:0] y_out,
    output logic [WORD_BITS:0]   rem_out
);

    ctl_t                 ctl_reg;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [WORD_BITS:0]   rem_reg, rem_next;
    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS+1:0] diff;

    assign rem_sh = {rem_in[WORD_BITS-1:0], x_in[WORD_BITS-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, y_in};

    // Step logic.
    always_comb
    begin
        acc_next = acc_in;
        x_next   = x_in;
        y_next   = y_in;
        rem_next = rem_in;
        if (ctl_in.kind == KIND_MUL)
        begin
            // Multiplicand in x, multiplier in y, partial product in acc.
            acc_next = y_in[0] ? (acc_in + x_in) : acc_in;
            x_next   = {x_in[WORD_BITS-2:0], 1'b0};
            y_next   = {1'b0, y_in[WORD_BITS-1:1]};
        end
        else if (ctl_in.kind == KIND_DIV)
        begin
            // Dividend in x, divisor in y, quotient in acc.
            x_next = {x_in[WORD_BITS-2:0], 1'b0};
            if (!diff[WORD_BITS+1])
            begin
                rem_next = diff[WORD_BITS:0];
                acc_next = {acc_in[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                acc_next = {acc_in[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
    end

    assign ctl_out = ctl_reg;
    assign acc_out = acc_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign rem_out = rem_reg;

endmodule

[rtl/int128_alu.sv]
// Each transfer passes the input register, WORD_BITS cells and the done register.
// Throughput: one item per cycle; busy stays low, and results leave in order.
// The multiply and divide run one bit per cell along a chain of WORD_BITS
// cells; other operations ride the same chain so every item has one latency.
// Reset clears all valid bits of the pipeline; no result is in flight after it.
// ----------------------------------------------------------------------------
// int128_alu
// Pipelined two's-complement ALU with add, sub, mul, div, logic, shifts,
// rotates and signed compare.
// ----------------------------------------------------------------------------
module int128_alu
    import alu128_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  op,
    output logic done,
    output out_t res
);

    ctl_t                 ctl_c [WORD_BITS+1];
    logic [WORD_BITS-1:0] acc_c [WORD_BITS+1];
    logic [WORD_BITS-1:0] x_c   [WORD_BITS+1];
    logic [WORD_BITS-1:0] y_c   [WORD_BITS+1];
    logic [WORD_BITS:0]   rem_c [WORD_BITS+1];
    ctl_t                 ctl_last;
    logic [WORD_BITS-1:0] fin;
    logic [127:0]         fin_full;
    logic                 done_reg;
    out_t                 res_reg, res_next;

    // The pipeline takes a transfer every cycle.
    assign busy = 1'b0;

    // Input stage.
    alu128_pre #(.WORD_BITS(WORD_BITS)) u_pre (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (start && !busy),
        .op    (op),
        .ctl   (ctl_c[0]),
        .acc   (acc_c[0]),
        .x     (x_c[0]),
        .y     (y_c[0]),
        .rem   (rem_c[0])
    );

    // Cell chain.
    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_cell
        alu128_cell #(.WORD_BITS(WORD_BITS)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_c[i]),
            .acc_in  (acc_c[i]),
            .x_in    (x_c[i]),
            .y_in    (y_c[i]),
            .rem_in  (rem_c[i]),
            .ctl_out (ctl_c[i+1]),
            .acc_out (acc_c[i+1]),
            .x_out   (x_c[i+1]),
            .y_out   (y_c[i+1]),
            .rem_out (rem_c[i+1])
        );
    end

    assign ctl_last = ctl_c[WORD_BITS];

    // Quotient sign fix and zero-divisor result.
    always_comb
    begin
        fin = acc_c[WORD_BITS];
        if (ctl_last.kind == KIND_DIV)
        begin
            if (ctl_last.dz)
            begin
                fin = '1;
            end
            else if (ctl_last.neg_q)
            begin
                fin = ~acc_c[WORD_BITS] + 1'b1;
            end
        end
    end

    assign fin_full = 128'(fin);

    always_comb
    begin
        res_next.result_high    = fin_full[127:64];
        res_next.result_low     = fin_full[63:0];
        res_next.less_than      = ctl_last.lt;
        res_next.equal          = ctl_last.eq;
        res_next.divide_by_zero = ctl_last.dz;
    end

    // Output strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_last.valid;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

[rtl/alu128_chk.sv]
// ----------------------------------------------------------------------------
// alu128_chk
// Port-level checks for the ALU, bound to the top level.
// ----------------------------------------------------------------------------
module alu128_chk
    import alu128_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input out_t res
);

    // Every accepted transfer gives a result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(WORD_BITS + 2) done)
        else $error("result strobe missing after accepted transfer");

    // Compare flags never come with the divide flag.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(res.divide_by_zero && (res.less_than || res.equal)))
        else $error("compare and divide flags together");

    // Equal and less-than exclude each other.
    a_eq_lt: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(res.equal && res.less_than))
        else $error("equal and less_than both set");

    // A zero divisor gives an all-ones low half.
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.divide_by_zero) |-> (res.result_low == '1))
        else $error("zero divisor result not all ones");

endmodule

bind int128_alu alu128_chk #(.WORD_BITS(WORD_BITS)) u_chk (.*);

[tb/tb_int128_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int128_alu
// Drives directed and random operations into the 128-bit ALU, predicts each
// result with a behavioral model and compares every result transfer in order.
// ----------------------------------------------------------------------------
module tb_int128_alu;
    import alu128_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t  op = '0;
    logic done;
    out_t res;

    in_t  pending_ops[$];
    out_t alu_results[$];
    int   errors = 0;
    bit   stim_done = 1'b0;
    int   gap_left = 0;

    int128_alu u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .done(done), .res(res)
    );

    always #5 clk = ~clk;

    // Behavioral prediction of one operation.
    function automatic out_t alu_predict(in_t x);
        out_t r;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] q;
        logic [255:0] dbl;
        int s;
        r = '0;
        a = {x.operand_a_high, x.operand_a_low};
        b = {x.operand_b_high, x.operand_b_low};
        q = '0;
        case (x.kind)
            KIND_ADD: q = a + b;
            KIND_SUB: q = a - b;
            KIND_MUL: q = a * b;
            KIND_DIV:
            begin
                if (b == '0)
                begin
                    q = '1;
                    r.divide_by_zero = 1'b1;
                end
                else
                begin
                    ma = a[127] ? -a : a;
                    mb = b[127] ? -b : b;
                    q = ma / mb;
                    if (a[127] ^ b[127])
                        q = -q;
                end
            end
            KIND_AND: q = a & b;
            KIND_OR:  q = a | b;
            KIND_XOR: q = a ^ b;
            KIND_NOT: q = ~a;
            KIND_SHL: q = (x.shift_amount >= 128) ? '0 : a << x.shift_amount;
            KIND_SHR: q = (x.shift_amount >= 128) ? '0 : a >> x.shift_amount;
            KIND_ROL, KIND_ROR:
            begin
                s = x.shift_amount % 128;
                dbl = {a, a};
                if (x.kind == KIND_ROL)
                    dbl = dbl << s;
                else
                    dbl = dbl >> s;
                q = (x.kind == KIND_ROL) ? dbl[255:128] : dbl[127:0];
            end
            KIND_CMP:
            begin
                r.equal = (a == b);
                r.less_than = ($signed(a) < $signed(b));
            end
            default: q = '0;
        endcase
        r.result_high = q[127:64];
        r.result_low = q[63:0];
        return r;
    endfunction

    // Random 64-bit value biased toward corner patterns.
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(0, 20));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic in_t make_op(logic [3:0] k, logic [127:0] a, logic [127:0] b,
                                    logic [7:0] sh);
        in_t x;
        x.kind = k;
        x.operand_a_high = a[127:64];
        x.operand_a_low = a[63:0];
        x.operand_b_high = b[127:64];
        x.operand_b_low = b[63:0];
        x.shift_amount = sh;
        return x;
    endfunction

    // Stimulus: directed corners, then random operations.
    initial
    begin
        in_t x;
        logic [127:0] mneg;
        mneg = {1'b1, 127'b0};
        pending_ops.push_back(make_op(KIND_ADD, '1, 128'd1, 8'd0));
        pending_ops.push_back(make_op(KIND_SUB, '0, 128'd1, 8'd0));
        pending_ops.push_back(make_op(KIND_MUL, '1, '1, 8'd0));
        pending_ops.push_back(make_op(KIND_DIV, 128'd7, '0, 8'd0));
        pending_ops.push_back(make_op(KIND_DIV, mneg, '1, 8'd0));
        pending_ops.push_back(make_op(KIND_DIV, -128'sd7, 128'd2, 8'd0));
        pending_ops.push_back(make_op(KIND_DIV, '1, mneg, 8'd0));
        pending_ops.push_back(make_op(KIND_AND, '1, 128'h5a5a, 8'd0));
        pending_ops.push_back(make_op(KIND_OR, '0, '1, 8'd0));
        pending_ops.push_back(make_op(KIND_XOR, '1, '1, 8'd0));
        pending_ops.push_back(make_op(KIND_NOT, '0, '0, 8'd0));
        pending_ops.push_back(make_op(KIND_SHL, '1, '0, 8'd128));
        pending_ops.push_back(make_op(KIND_SHL, '1, '0, 8'd127));
        pending_ops.push_back(make_op(KIND_SHR, '1, '0, 8'd64));
        pending_ops.push_back(make_op(KIND_SHR, '1, '0, 8'd255));
        pending_ops.push_back(make_op(KIND_ROL, mneg | 1, '0, 8'd128));
        pending_ops.push_back(make_op(KIND_ROL, mneg | 1, '0, 8'd1));
        pending_ops.push_back(make_op(KIND_ROR, mneg | 1, '0, 8'd200));
        pending_ops.push_back(make_op(KIND_CMP, mneg, '1, 8'd0));
        pending_ops.push_back(make_op(KIND_CMP, '1, '1, 8'd0));
        pending_ops.push_back(make_op(KIND_CMP, 128'd1, mneg, 8'd0));
        pending_ops.push_back(make_op(4'd13, '1, '1, 8'd5));
        pending_ops.push_back(make_op(4'd15, '1, '1, 8'd5));
        repeat (550)
        begin
            x.kind = 4'($urandom_range(0, 15));
            x.operand_a_high = rand_word();
            x.operand_a_low = rand_word();
            x.operand_b_high = rand_word();
            x.operand_b_low = rand_word();
            if ($urandom_range(0, 3) == 0)
                x.shift_amount = 8'($urandom_range(0, 255));
            else
                x.shift_amount = 8'($urandom_range(0, 128));
            if (x.kind == KIND_CMP && $urandom_range(0, 3) == 0)
                {x.operand_b_high, x.operand_b_low} = {x.operand_a_high, x.operand_a_low};
            pending_ops.push_back(x);
        end
        stim_done = 1'b1;
    end

    // Driver: one transfer when start is high and busy is low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
                alu_results.push_back(alu_predict(op));
            if (start && busy)
            begin
                // Hold the current item.
            end
            else if (gap_left > 0 || pending_ops.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                op <= pending_ops.pop_front();
                start <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                          : $urandom_range(1, 3);
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        out_t e;
        if (rst_n && done)
        begin
            if (alu_results.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                e = alu_results.pop_front();
                if (res.result_high !== e.result_high)
                begin
                    $error("result_high expected %h actual %h", e.result_high, res.result_high);
                    errors++;
                end
                if (res.result_low !== e.result_low)
                begin
                    $error("result_low expected %h actual %h", e.result_low, res.result_low);
                    errors++;
                end
                if (res.less_than !== e.less_than)
                begin
                    $error("less_than expected %b actual %b", e.less_than, res.less_than);
                    errors++;
                end
                if (res.equal !== e.equal)
                begin
                    $error("equal expected %b actual %b", e.equal, res.equal);
                    errors++;
                end
                if (res.divide_by_zero !== e.divide_by_zero)
                begin
                    $error("divide_by_zero expected %b actual %b",
                           e.divide_by_zero, res.divide_by_zero);
                    errors++;
                end
            end
        end
    end

    // Reset, then wait for the stimulus to drain and the pipeline to empty.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && pending_ops.size() == 0);
        @(posedge clk);
        while (start || alu_results.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
        if (errors == 0 && alu_results.size() == 0)
            $display("int128_alu: match");
        else
            $display("int128_alu: mismatch");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("int128_alu: mismatch");
        $finish;
    end
endmodule

[int128_alu.f]
rtl/alu128_pkg.sv
rtl/alu128_pre.sv
rtl/alu128_cell.sv
rtl/int128_alu.sv
rtl/alu128_chk.sv
tb/tb_int128_alu.sv
